// ===== hw/rtl/sha256mh_pkg.sv =====
// package for the sha-256 message hasher
// transaction structs, sequencer states, round constants and initial hash values
// no dependencies
package sha256mh_pkg;

  // input transaction: one message byte (or none) and the end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_item_t;

  // result transaction: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } hsh_state_t;

  // round unit sequencer
  typedef enum logic [1:0] {
    RND_IDLE,
    RND_RUN,
    RND_ADD
  } rnd_state_t;

  // requests from the top-level sequencer to the round unit
  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       init;
  } rnd_ctl_t;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  // initial hash values, word 0 in the low slot
  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== hw/rtl/sha256_message_hasher.sv =====
// top level of the sha-256 message hasher: byte intake, padding sequencer, digest output
// instantiates sha256mh_round, depends on sha256mh_pkg
// Hashes a byte stream with SHA-256. Each input transaction carries one message byte
// (when byte_present is set) and a last flag; last closes the message, with or without
// a byte, and an empty message is hashed by a transaction with no byte and last set.
// Bytes are shifted one per cycle, while in_stall is low, into a 64-byte line; each
// full block is compressed by one shared round unit after its 64th byte (64 rounds,
// then the chaining add), during which in_stall is high. After last the block inserts
// the 0x80 marker, zero fill and the 64-bit big-endian bit count one byte per cycle
// (one or two more blocks), then shows the eight digest words, word 0 first, one per
// out transaction, and restarts for the next message. No input is taken while digest
// words are pending.
module sha256_message_hasher
  import sha256mh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  hsh_state_t  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;           // bytes held in the current block
  logic [63:0] bit_total_r, bit_total_nxt; // message length in bits, wraps
  logic        pad_r, pad_nxt;             // message closed, padding in progress
  logic        first_pad_r, first_pad_nxt; // marker byte still to be written
  logic        final_blk_r, final_blk_nxt; // current block carries the length
  logic [2:0]  idx_r, idx_nxt;             // digest word on the output

  rnd_ctl_t         ctl;
  logic             rnd_done;
  logic [7:0][31:0] chain;
  logic [7:0]       len_byte, pad_byte;

  sha256mh_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .done  (rnd_done),
    .chain (chain)
  );

  // big-endian length byte for slot 56..63 of the final block
  assign len_byte = 8'(bit_total_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    if (first_pad_r) begin
      pad_byte = PAD_MARK;
    end else if (final_blk_r && (fill_r >= LEN_POS)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_present && (fill_r == LAST_FILL)) begin
            state_nxt = ST_COMP;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: if (fill_r == LAST_FILL) state_nxt = ST_COMP;
      ST_COMP: begin
        if (rnd_done) begin
          // data block done; padding may still owe the marker or the length block
          if (!pad_r) begin
            state_nxt = ST_IDLE;
          end else if (first_pad_r || !final_blk_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: if (!out_stall && (idx_r == LAST_IDX)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    fill_nxt      = fill_r;
    bit_total_nxt = bit_total_r;
    pad_nxt       = pad_r;
    first_pad_nxt = first_pad_r;
    final_blk_nxt = final_blk_r;
    idx_nxt       = idx_r;
    ctl           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pad_nxt       = in_data.last;
          first_pad_nxt = 1'b1;
          if (in_data.byte_present) begin
            ctl.load_byte = 1'b1;
            ctl.byte_val  = in_data.data_byte;
            fill_nxt      = fill_r + 6'd1;
            bit_total_nxt = bit_total_r + 64'd8;
            ctl.start     = (fill_r == LAST_FILL);
          end
        end
      end
      ST_PAD: begin
        ctl.load_byte = 1'b1;
        ctl.byte_val  = pad_byte;
        fill_nxt      = fill_r + 6'd1;
        first_pad_nxt = 1'b0;
        // the length fits behind the marker only if the marker lands before slot 56
        if (first_pad_r) final_blk_nxt = (fill_r < LEN_POS);
        ctl.start = (fill_r == LAST_FILL);
      end
      ST_COMP: begin
        if (rnd_done && pad_r && !first_pad_r && !final_blk_r) final_blk_nxt = 1'b1;
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            // restart for the next message
            ctl.init      = 1'b1;
            fill_nxt      = '0;
            bit_total_nxt = '0;
            pad_nxt       = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bit_total_r <= '0;
      pad_r       <= 1'b0;
      first_pad_r <= 1'b0;
      final_blk_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bit_total_r <= bit_total_nxt;
      pad_r       <= pad_nxt;
      first_pad_r <= first_pad_nxt;
      final_blk_r <= final_blk_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // handshake and result payload, all from registers
  assign in_stall              = (state_r != ST_IDLE);
  assign out_valid             = (state_r == ST_OUT);
  assign out_data.digest_word  = chain[idx_r];
  assign out_data.word_index   = idx_r;
  assign out_data.last_word    = (idx_r == LAST_IDX);

endmodule

// ===== hw/rtl/sha256mh_round.sv =====
// shared round unit: block buffer / schedule shift line, working variables, chaining words
// one compression round per cycle under a small sequencer
// depends on sha256mh_pkg
module sha256mh_round
  import sha256mh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rnd_ctl_t         ctl,
  output logic             done,
  output logic [7:0][31:0] chain
);

  rnd_state_t       state_r, state_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [511:0]     msg_r, msg_nxt;
  logic [7:0][31:0] wv_r, wv_nxt;
  logic [7:0][31:0] chain_r, chain_nxt;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, bs0, bs1, ch, maj, t1, t2;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  // window of the schedule line: word 0 is the current round's word
  assign w0  = msg_r[511:480];
  assign w1  = msg_r[479:448];
  assign w9  = msg_r[223:192];
  assign w14 = msg_r[63:32];

  always_comb begin
    s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
    bs1   = ror(wv_r[4], 6) ^ ror(wv_r[4], 11) ^ ror(wv_r[4], 25);
    bs0   = ror(wv_r[0], 2) ^ ror(wv_r[0], 13) ^ ror(wv_r[0], 22);
    ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1    = wv_r[7] + bs1 + ch + K_TABLE[rnd_r] + w0;
    t2    = bs0 + maj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      RND_IDLE: if (ctl.start) state_nxt = RND_RUN;
      RND_RUN:  if (rnd_r == LAST_RND) state_nxt = RND_ADD;
      RND_ADD:  state_nxt = RND_IDLE;
      default:  state_nxt = RND_IDLE;
    endcase
  end

  always_comb begin
    rnd_nxt   = rnd_r;
    msg_nxt   = msg_r;
    wv_nxt    = wv_r;
    chain_nxt = chain_r;
    done      = 1'b0;
    unique case (state_r)
      RND_IDLE: begin
        if (ctl.load_byte) msg_nxt = {msg_r[503:0], ctl.byte_val};
        if (ctl.start) begin
          wv_nxt  = chain_r;
          rnd_nxt = '0;
        end
        if (ctl.init) chain_nxt = H_INIT;
      end
      RND_RUN: begin
        msg_nxt = {msg_r[479:0], w_new};
        wv_nxt  = {wv_r[6:4], wv_r[3] + t1, wv_r[2:0], t1 + t2};
        rnd_nxt = rnd_r + 6'd1;
      end
      RND_ADD: begin
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + wv_r[i];
        done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RND_IDLE;
      rnd_r   <= '0;
      chain_r <= H_INIT;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
    wv_r  <= wv_nxt;
  end

  assign chain = chain_r;

endmodule

// ===== hw/rtl/sha256mh_checker.sv =====
// port-level checker for the sha-256 message hasher, bound to the top level
// depends on sha256mh_pkg and sha256_message_hasher
module sha256mh_checker
  import sha256mh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");

  // no input transaction while digest words are pending
  a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // digest words come out in order without gaps
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && (out_data.word_index == 3'($past(out_data.word_index) + 3'd1)))
    else $error("digest word sequence broken");

  // the closing word is word seven
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_word |-> out_data.word_index == LAST_IDX)
    else $error("last word flag on wrong index");

  // after the closing word the block is ready for the next message
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_word |=> !out_valid && !in_stall)
    else $error("no restart after digest");

endmodule

bind sha256_message_hasher sha256mh_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
